FILE: hw/rtl/ubds_pkg.sv
// ---------------------------------------------------------------------------
// UART baud divisor select package
// Shared widths, status codes and the side-band item type of the pipeline.
// ---------------------------------------------------------------------------
package ubds_pkg;

  // Field widths of the stream items.
  localparam int CLK_W     = 28;
  localparam int BAUD_W    = 24;
  localparam int DIVOUT_W  = 16;

  // Width of every divider lane: dividend, divisor and quotient.
  localparam int DW        = 29;

  // Widths of the first-pass quotients.
  localparam int N13_W     = 25;
  localparam int N16_W     = 24;
  localparam int QR_W      = 25;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [DIVOUT_W-1:0] DIV_MAX = '1;

  // Item data that travels beside the divider cells.
  typedef struct packed {
    logic              mode;
    logic [CLK_W-1:0]  clk_hz;
    logic [BAUD_W-1:0] baud;
    logic [N13_W-1:0]  n13;
    logic [N16_W-1:0]  n16;
    logic [QR_W-1:0]   qr;
  } side_t;

endpackage

FILE: hw/rtl/uart_baud_divisor_select.sv
// Throughput: one item per cycle while the output side takes results.
// The latency is set by two rows of 29 divider cells, one for the divisors
// and one for the baud rates they produce, plus a middle and an output stage.
// Reset clears all valid bits; no items are in flight after reset.
// ---------------------------------------------------------------------------
// UART baud divisor select
// Computes a UART divisor latch value from a reference clock and a baud rate,
// choosing between 13x and 16x oversampling or giving a rounded 16x divisor.
// ---------------------------------------------------------------------------
module uart_baud_divisor_select (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // clock_hz [27:0], baud_rate [51:28], zero fill
  input  logic        s_axis_tuser,  // mode [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // divisor [15:0], oversample_16 [16], zero fill
  output logic [1:0]  m_axis_tuser   // status [1:0]
);

  localparam int DW     = ubds_pkg::DW;
  localparam int CLK_W  = ubds_pkg::CLK_W;
  localparam int BAUD_W = ubds_pkg::BAUD_W;

  logic                en;
  logic [CLK_W-1:0]    in_clk;
  logic [BAUD_W-1:0]   in_baud;
  logic [DW-1:0]       in_baud_w;
  logic [DW-1:0]       b13;
  logic [DW-1:0]       b16;
  logic [DW-1:0]       rnd_dvd;
  logic [DW-1:0]       q13;
  logic [DW-1:0]       q16;
  logic [DW-1:0]       qr;
  ubds_pkg::side_t     in_side;
  ubds_pkg::side_t     s1 [DW];
  logic [DW-1:0]       v1;
  ubds_pkg::side_t     mid_next;
  ubds_pkg::side_t     mid;
  logic                mid_v;
  logic [DW-1:0]       n13_w;
  logic [DW-1:0]       d13;
  logic [DW-1:0]       d16;
  logic [DW-1:0]       r13;
  logic [DW-1:0]       r16;
  ubds_pkg::side_t     s2 [DW];
  logic [DW-1:0]       v2;
  ubds_pkg::side_t     fin;
  logic [DW-1:0]       baud_f;
  logic [DW-1:0]       e13;
  logic [DW-1:0]       e16;
  logic                pick16;
  logic [DW-1:0]       sel_n;
  logic                sel_os;
  logic [15:0]         div_next;
  logic                os_next;
  logic [1:0]          st_next;
  logic [15:0]         div_q;
  logic                os_q;
  logic [1:0]          st_q;

  // The whole pipeline moves unless a result waits on a stalled output.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // First pass operands: 13 * baud, 16 * baud and clock + 8 * baud.
  always_comb begin
    in_clk    = s_axis_tdata[CLK_W-1:0];
    in_baud   = s_axis_tdata[CLK_W+BAUD_W-1:CLK_W];
    in_baud_w = {{(DW-BAUD_W){1'b0}}, in_baud};
    b13       = (in_baud_w << 3) + (in_baud_w << 2) + in_baud_w;
    b16       = in_baud_w << 4;
    rnd_dvd   = {{(DW-CLK_W){1'b0}}, in_clk} + (in_baud_w << 3);
    in_side        = '0;
    in_side.mode   = s_axis_tuser;
    in_side.clk_hz = in_clk;
    in_side.baud   = in_baud;
  end

  ubds_div_chain #(.DW(DW)) u_div13 (
    .clk (clk), .en (en),
    .dvd ({{(DW-CLK_W){1'b0}}, in_clk}), .dvs (b13), .quo (q13)
  );

  ubds_div_chain #(.DW(DW)) u_div16 (
    .clk (clk), .en (en),
    .dvd ({{(DW-CLK_W){1'b0}}, in_clk}), .dvs (b16), .quo (q16)
  );

  ubds_div_chain #(.DW(DW)) u_divrnd (
    .clk (clk), .en (en),
    .dvd (rnd_dvd), .dvs (b16), .quo (qr)
  );

  // Side-band line beside the first pass.
  always_ff @(posedge clk) begin
    if (en) begin
      s1[0] <= in_side;
      for (int k = 1; k < DW; k++) begin
        s1[k] <= s1[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= '0;
      mid_v <= 1'b0;
    end else if (en) begin
      v1    <= {v1[DW-2:0], s_axis_tvalid};
      mid_v <= v1[DW-1];
    end
  end

  // Middle stage captures the first-pass quotients.
  always_comb begin
    mid_next     = s1[DW-1];
    mid_next.n13 = q13[ubds_pkg::N13_W-1:0];
    mid_next.n16 = q16[ubds_pkg::N16_W-1:0];
    mid_next.qr  = qr[ubds_pkg::QR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid <= mid_next;
    end
  end

  // Second pass divisors: 13 * n13 and 16 * n16.
  always_comb begin
    n13_w = {{(DW-ubds_pkg::N13_W){1'b0}}, mid.n13};
    d13   = (n13_w << 3) + (n13_w << 2) + n13_w;
    d16   = {{(DW-ubds_pkg::N16_W){1'b0}}, mid.n16} << 4;
  end

  ubds_div_chain #(.DW(DW)) u_rate13 (
    .clk (clk), .en (en),
    .dvd ({{(DW-CLK_W){1'b0}}, mid.clk_hz}), .dvs (d13), .quo (r13)
  );

  ubds_div_chain #(.DW(DW)) u_rate16 (
    .clk (clk), .en (en),
    .dvd ({{(DW-CLK_W){1'b0}}, mid.clk_hz}), .dvs (d16), .quo (r16)
  );

  // Side-band line beside the second pass.
  always_ff @(posedge clk) begin
    if (en) begin
      s2[0] <= mid;
      for (int k = 1; k < DW; k++) begin
        s2[k] <= s2[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= '0;
    end else if (en) begin
      v2 <= {v2[DW-2:0], mid_v};
    end
  end

  // Error compare, selection, saturation and the zero-divisor case.
  always_comb begin
    fin    = s2[DW-1];
    baud_f = {{(DW-BAUD_W){1'b0}}, fin.baud};
    e13    = (baud_f >= r13) ? (baud_f - r13) : (r13 - baud_f);
    e16    = (baud_f >= r16) ? (baud_f - r16) : (r16 - baud_f);
    if (fin.mode) begin
      sel_n  = {{(DW-ubds_pkg::QR_W){1'b0}}, fin.qr};
      sel_os = 1'b1;
    end else begin
      pick16 = (fin.n16 != '0) && (e13 >= e16);
      sel_n  = pick16 ? {{(DW-ubds_pkg::N16_W){1'b0}}, fin.n16}
                      : {{(DW-ubds_pkg::N13_W){1'b0}}, fin.n13};
      sel_os = pick16;
    end
    if (!fin.mode) begin
      pick16 = (fin.n16 != '0) && (e13 >= e16);
    end else begin
      pick16 = 1'b1;
    end
    os_next = sel_os;
    if (fin.baud == '0) begin
      div_next = ubds_pkg::DIV_MAX;
      os_next  = 1'b1;
      st_next  = ubds_pkg::ST_SAT;
    end else if (sel_n == '0) begin
      div_next = '0;
      st_next  = ubds_pkg::ST_ZERO;
    end else if (sel_n > {{(DW-16){1'b0}}, ubds_pkg::DIV_MAX}) begin
      div_next = ubds_pkg::DIV_MAX;
      st_next  = ubds_pkg::ST_SAT;
    end else begin
      div_next = sel_n[15:0];
      st_next  = ubds_pkg::ST_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= v2[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_q <= div_next;
      os_q  <= os_next;
      st_q  <= st_next;
    end
  end

  assign m_axis_tdata = {7'd0, os_q, div_q};
  assign m_axis_tuser = st_q;

endmodule

FILE: hw/rtl/ubds_div_cell.sv
// ---------------------------------------------------------------------------
// Divider cell
// One restoring-division step: takes one dividend bit, makes one quotient bit
// and hands remainder, dividend, quotient and divisor to the next cell.
// ---------------------------------------------------------------------------
module ubds_div_cell #(
  parameter int DW = ubds_pkg::DW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_in,
  input  logic [DW-1:0] dvd_in,
  input  logic [DW-1:0] quo_in,
  input  logic [DW-1:0] dvs_in,
  output logic [DW-1:0] rem_out,
  output logic [DW-1:0] dvd_out,
  output logic [DW-1:0] quo_out,
  output logic [DW-1:0] dvs_out
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial    = {rem_in, dvd_in[DW-1]};
    diff     = trial - {1'b0, dvs_in};
    ge       = (trial >= {1'b0, dvs_in});
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  // Step registers.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      dvd_out <= {dvd_in[DW-2:0], 1'b0};
      quo_out <= {quo_in[DW-2:0], ge};
      dvs_out <= dvs_in;
    end
  end

endmodule

FILE: hw/rtl/ubds_div_chain.sv
// ---------------------------------------------------------------------------
// Divider chain
// A row of DW registered divider cells; the operands enter the first cell
// and the quotient leaves the last.
// ---------------------------------------------------------------------------
module ubds_div_chain #(
  parameter int DW = ubds_pkg::DW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dvd,
  input  logic [DW-1:0] dvs,
  output logic [DW-1:0] quo
);

  logic [DW-1:0] rem_s [DW+1];
  logic [DW-1:0] dvd_s [DW+1];
  logic [DW-1:0] quo_s [DW+1];
  logic [DW-1:0] dvs_s [DW+1];

  // The first cell starts from a clear remainder and quotient.
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign dvd_s[0] = dvd;
  assign dvs_s[0] = dvs;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    ubds_div_cell #(.DW(DW)) u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (rem_s[k]),
      .dvd_in  (dvd_s[k]),
      .quo_in  (quo_s[k]),
      .dvs_in  (dvs_s[k]),
      .rem_out (rem_s[k+1]),
      .dvd_out (dvd_s[k+1]),
      .quo_out (quo_s[k+1]),
      .dvs_out (dvs_s[k+1])
    );
  end

  assign quo = quo_s[DW];

endmodule

FILE: hw/rtl/ubds_checker.sv
// ---------------------------------------------------------------------------
// UART baud divisor select checker
// Port-level properties of the divisor select block, bound to the top level.
// ---------------------------------------------------------------------------
module ubds_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Input stalls only while a result waits on the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // A zero-divisor result carries a zero divisor.
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ubds_pkg::ST_ZERO) |-> m_axis_tdata[15:0] == 16'd0)
    else $error("zero status with nonzero divisor");

  // A saturated result carries the largest divisor.
  a_sat_div: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == ubds_pkg::ST_SAT) |-> m_axis_tdata[15:0] == 16'hFFFF)
    else $error("saturated status with wrong divisor");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind uart_baud_divisor_select ubds_checker u_ubds_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
